### sv/thin_plate_spline_evaluator_assert.svh
// Assertion macros used by the thin-plate spline evaluator checker
`ifndef THIN_PLATE_SPLINE_EVALUATOR_ASSERT_SVH
`define THIN_PLATE_SPLINE_EVALUATOR_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tps_pkg.sv
// Constants shared by the thin-plate spline evaluator and its checker
package tps_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [2:0] CFG_NUM_POINTS = 3'd0;
    localparam logic [2:0] CFG_U_OFFSET   = 3'd1;
    localparam logic [2:0] CFG_U_GAIN_X   = 3'd2;
    localparam logic [2:0] CFG_U_GAIN_Y   = 3'd3;
    localparam logic [2:0] CFG_V_OFFSET   = 3'd4;
    localparam logic [2:0] CFG_V_GAIN_X   = 3'd5;
    localparam logic [2:0] CFG_V_GAIN_Y   = 3'd6;

    localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;

    localparam int LOG_ITERS = 16;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam int MUL_W   = 35;   // shared multiplier operand width, signed
    localparam int PROD_W  = 2 * MUL_W;
    localparam int CHUNK_W = 24;   // coefficient slice per multiply
    localparam int KCH_W   = 28;   // kernel slice per multiply
    localparam int KERN_W  = 2 * KCH_W;
    localparam int R_W     = 34;
    localparam int LN_W    = 24;
    localparam int SH_W    = 8;
    localparam int AFF_SH  = 20;   // Q.36 product to Q.56
    localparam int OFF_SH  = 24;   // Q.32 offset to Q.56
    localparam int RND_SH  = 40;   // Q.56 to Q.16

endpackage

### sv/tps_ram.sv
// Generic single-port-write, registered-read RAM
module tps_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/thin_plate_spline_evaluator.sv
// Thin-plate spline evaluator: control point table, sequencer and shared multiplier
//
// A load item writes one table entry. An evaluate item runs under a sequencer
// that feeds one registered 35x35 signed multiplier: first the affine part,
// sliced into NC coefficient slices of 24 bits (2 at COEF_BITS = 48), then
// every active control point, which reads the table, squares dx and dy and
// sums them, and, when its distance is not zero, runs the 16 squaring steps of
// the log unit and multiplies the kernel by the weights. The drain and finish
// states round, saturate and present the result. The result sits in an output
// register, so loads are taken while it waits; the next evaluate starts once
// the previous result has been registered. The input side is stalled while an
// evaluation runs.
module thin_plate_spline_evaluator
    import tps_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COEF_BITS  = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_index,
    input  logic [COEF_BITS-1:0]        i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [5:0]                  i_entry_index,
    input  logic [15:0]                 i_ctrl_x,
    input  logic [15:0]                 i_ctrl_y,
    input  logic signed [COEF_BITS-1:0] i_weight_u,
    input  logic signed [COEF_BITS-1:0] i_weight_v,
    input  logic [15:0]                 i_point_x,
    input  logic [15:0]                 i_point_y,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_map_u,
    output logic signed [31:0]          o_map_v,
    output logic                        o_saturated
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int JW    = $clog2(MAX_POINTS + 1);
    localparam int NC    = (COEF_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int CW    = (NC > 1) ? $clog2(NC) : 1;
    localparam int WPW   = NC * CHUNK_W;
    localparam int ACC_W = KERN_W + COEF_BITS + JW + 2;
    localparam int QW    = ACC_W - RND_SH;
    localparam int RAM_W = 32 + 2 * COEF_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_AFF, S_PT_RD, S_PT_DX, S_PT_DY, S_PT_R, S_LOG_SQ, S_LOG_UPD,
        S_LN, S_LN_W, S_K_W, S_KMUL, S_DRAIN, S_FIN
    } t_state;

    typedef struct packed {
        logic            en;
        logic            sel;
        logic [SH_W-1:0] sh;
    } t_mtag;

    t_state                    r_state, n_state;
    logic [6:0]                r_num, n_num;
    logic [COEF_BITS-1:0]      r_coef [6];
    logic [COEF_BITS-1:0]      n_coef [6];
    logic [15:0]               r_px, n_px, r_py, n_py, r_dy, n_dy;
    logic [JW-1:0]             r_j, n_j;
    logic [1:0]                r_t, n_t;
    logic [CW-1:0]             r_c, n_c;
    logic [R_W-1:0]            r_r, n_r;
    logic [31:0]               r_m, n_m;
    logic [5:0]                r_e, n_e;
    logic [LOG_ITERS-1:0]      r_frac, n_frac;
    logic [4:0]                r_it, n_it;
    logic [KERN_W-1:0]         r_k, n_k;
    logic signed [ACC_W-1:0]   r_acc [2];
    logic signed [ACC_W-1:0]   n_acc [2];
    logic signed [PROD_W-1:0]  r_prod;
    t_mtag                     r_tag, n_tag;
    logic                      r_out_valid, n_out_valid;
    logic signed [31:0]        r_map_u, n_map_u, r_map_v, n_map_v;
    logic                      r_sat, n_sat;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [JW-1:0]             lim;
    logic [RAM_W-1:0]          ram_rdata;
    logic                      ram_we;
    logic [15:0]               ram_x, ram_y;
    logic [COEF_BITS-1:0]      ram_wu, ram_wv;
    logic                      in_acc;

    // coefficient slice: low slices unsigned, top slice signed
    function automatic logic signed [MUL_W-1:0] coef_slice(
        input logic [COEF_BITS-1:0] w,
        input logic [CW-1:0]        c
    );
        logic signed [WPW-1:0]  wpad;
        logic [CHUNK_W-1:0]     s;
        wpad = WPW'($signed(w));
        s    = wpad[c*CHUNK_W +: CHUNK_W];
        if (c == CW'(NC - 1)) begin
            coef_slice = {{(MUL_W - CHUNK_W){s[CHUNK_W-1]}}, s};
        end else begin
            coef_slice = {{(MUL_W - CHUNK_W){1'b0}}, s};
        end
    endfunction

    // round half up to Q16.16 and clip; bit 32 flags the clip
    function automatic logic [32:0] finish(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] v;
        logic [QW-1:0]           q;
        v = a + (ACC_W'(1) <<< (RND_SH - 1));
        q = v[ACC_W-1:RND_SH];
        if (q[QW-1:31] == {(QW - 31){q[31]}}) begin
            finish = {1'b0, q[31:0]};
        end else if (q[QW-1]) begin
            finish = {1'b1, SAT_NEG};
        end else begin
            finish = {1'b1, SAT_POS};
        end
    endfunction

    assign lim = (32'(r_num) > MAX_POINTS) ? JW'(MAX_POINTS) : JW'(r_num);
    assign in_acc = i_in_valid && (r_state == S_IDLE);
    assign ram_we = in_acc && (i_cmd == CMD_LOAD) && (32'(i_entry_index) < MAX_POINTS);
    assign {ram_x, ram_y, ram_wu, ram_wv} = ram_rdata;

    tps_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(AW'(i_entry_index)),
        .i_wdata({i_ctrl_x, i_ctrl_y, i_weight_u, i_weight_v}),
        .i_raddr(r_j[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign prod_c   = mul_a * mul_b;
    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        logic [16:0]            dx;
        logic [R_W-1:0]         rsum;
        logic [5:0]             e;
        logic [32:0]            m2;
        logic signed [6:0]      l2_int;
        logic signed [PROD_W-1:0] lnp;
        logic [32:0]            fu, fv;
        logic                   last;

        n_state     = r_state;
        n_num       = r_num;
        n_coef      = r_coef;
        n_px        = r_px;
        n_py        = r_py;
        n_dy        = r_dy;
        n_j         = r_j;
        n_t         = r_t;
        n_c         = r_c;
        n_r         = r_r;
        n_m         = r_m;
        n_e         = r_e;
        n_frac      = r_frac;
        n_it        = r_it;
        n_k         = r_k;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_map_u     = r_map_u;
        n_map_v     = r_map_v;
        n_sat       = r_sat;
        n_tag       = '0;
        mul_a       = '0;
        mul_b       = '0;
        dx          = '0;
        rsum        = r_r + R_W'(r_prod[31:0]);
        e           = '0;
        m2          = r_prod[63:31];
        l2_int      = $signed({1'b0, r_e}) - 7'sd8;
        lnp         = r_prod + (PROD_W'(1) <<< 31);
        fu          = finish(r_acc[0]);
        fv          = finish(r_acc[1]);
        last        = (r_c == CW'(NC - 1)) && (r_t == 2'd3);

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_POINTS: n_num = i_cfg_data[6:0];
                CFG_U_OFFSET, CFG_U_GAIN_X, CFG_U_GAIN_Y,
                CFG_V_OFFSET, CFG_V_GAIN_X, CFG_V_GAIN_Y:
                    n_coef[i_cfg_index - CFG_U_OFFSET] = i_cfg_data;
                default: ;
            endcase
        end

        // retire the product issued last cycle
        if (r_tag.en) begin
            n_acc[r_tag.sel] = r_acc[r_tag.sel] + (prod_ext <<< r_tag.sh);
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_EVAL)) begin
                    n_px     = i_point_x;
                    n_py     = i_point_y;
                    n_acc[0] = ACC_W'($signed(r_coef[CFG_U_OFFSET - CFG_U_OFFSET])) <<< OFF_SH;
                    n_acc[1] = ACC_W'($signed(r_coef[CFG_V_OFFSET - CFG_U_OFFSET])) <<< OFF_SH;
                    n_t      = '0;
                    n_c      = '0;
                    n_state  = S_AFF;
                end
            end
            S_AFF: begin
                mul_a     = coef_slice(r_coef[{1'b0, r_t} + {2'b00, r_t[1]} + 3'd1], r_c);
                mul_b     = MUL_W'(r_t[0] ? r_py : r_px);
                n_tag.en  = 1'b1;
                n_tag.sel = r_t[1];
                n_tag.sh  = SH_W'(AFF_SH + CHUNK_W * int'(r_c));
                if (r_c == CW'(NC - 1)) begin
                    n_c = '0;
                    n_t = r_t + 2'd1;
                end else begin
                    n_c = r_c + CW'(1);
                end
                if (last) begin
                    n_j     = '0;
                    n_state = (lim == '0) ? S_DRAIN : S_PT_RD;
                end
            end
            S_PT_RD: begin
                n_state = S_PT_DX;
            end
            S_PT_DX: begin
                dx      = (r_px > ram_x) ? 17'(r_px - ram_x) : 17'(ram_x - r_px);
                n_dy    = (r_py > ram_y) ? (r_py - ram_y) : (ram_y - r_py);
                mul_a   = MUL_W'(dx);
                mul_b   = MUL_W'(dx);
                n_state = S_PT_DY;
            end
            S_PT_DY: begin
                n_r     = R_W'(r_prod[31:0]);
                mul_a   = MUL_W'(r_dy);
                mul_b   = MUL_W'(r_dy);
                n_state = S_PT_R;
            end
            S_PT_R: begin
                for (int b = 0; b < R_W; b++) begin
                    if (rsum[b]) begin
                        e = 6'(b);
                    end
                end
                n_r    = rsum;
                n_e    = e;
                n_frac = '0;
                n_it   = '0;
                if (e <= 6'd31) begin
                    n_m = 32'(rsum << (6'd31 - e));
                end else begin
                    n_m = 32'(rsum >> (e - 6'd31));
                end
                if (rsum == '0) begin
                    // zero distance adds nothing; move to the next point
                    n_j     = r_j + JW'(1);
                    n_state = (r_j + JW'(1) == lim) ? S_DRAIN : S_PT_RD;
                end else begin
                    n_state = S_LOG_SQ;
                end
            end
            S_LOG_SQ: begin
                mul_a   = MUL_W'(r_m);
                mul_b   = MUL_W'(r_m);
                n_state = S_LOG_UPD;
            end
            S_LOG_UPD: begin
                n_frac = {r_frac[LOG_ITERS-2:0], m2[32]};
                n_m    = m2[32] ? m2[32:1] : m2[31:0];
                n_it   = r_it + 5'd1;
                n_state = (r_it == 5'(LOG_ITERS - 1)) ? S_LN : S_LOG_SQ;
            end
            S_LN: begin
                mul_a   = MUL_W'($signed({l2_int, r_frac}));
                mul_b   = MUL_W'(LN2_Q32);
                n_state = S_LN_W;
            end
            S_LN_W: begin
                mul_a   = MUL_W'(r_r);
                mul_b   = MUL_W'($signed(lnp[32 +: LN_W]));
                n_state = S_K_W;
            end
            S_K_W: begin
                n_k     = r_prod[KERN_W-1:0];
                n_t     = '0;
                n_c     = '0;
                n_state = S_KMUL;
            end
            S_KMUL: begin
                // r_t holds {weight select, kernel slice}
                if (r_t[0]) begin
                    mul_a = MUL_W'($signed(r_k[KERN_W-1:KCH_W]));
                end else begin
                    mul_a = MUL_W'(r_k[KCH_W-1:0]);
                end
                mul_b     = coef_slice(r_t[1] ? ram_wv : ram_wu, r_c);
                n_tag.en  = 1'b1;
                n_tag.sel = r_t[1];
                n_tag.sh  = SH_W'(KCH_W * int'(r_t[0]) + CHUNK_W * int'(r_c));
                if (r_c == CW'(NC - 1)) begin
                    n_c = '0;
                    n_t = r_t + 2'd1;
                end else begin
                    n_c = r_c + CW'(1);
                end
                if (last) begin
                    n_j     = r_j + JW'(1);
                    n_state = (r_j + JW'(1) == lim) ? S_DRAIN : S_PT_RD;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_map_u     = $signed(fu[31:0]);
                    n_map_v     = $signed(fv[31:0]);
                    n_sat       = fu[32] | fv[32];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= '0;
            for (int i = 0; i < 6; i++) begin
                r_coef[i] <= '0;
            end
            r_tag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num       <= n_num;
            r_coef      <= n_coef;
            r_tag       <= n_tag;
            r_out_valid <= n_out_valid;
        end
        r_px    <= n_px;
        r_py    <= n_py;
        r_dy    <= n_dy;
        r_j     <= n_j;
        r_t     <= n_t;
        r_c     <= n_c;
        r_r     <= n_r;
        r_m     <= n_m;
        r_e     <= n_e;
        r_frac  <= n_frac;
        r_it    <= n_it;
        r_k     <= n_k;
        r_acc   <= n_acc;
        r_prod  <= prod_c;
        r_map_u <= n_map_u;
        r_map_v <= n_map_v;
        r_sat   <= n_sat;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_map_u     = r_map_u;
    assign o_map_v     = r_map_v;
    assign o_saturated = r_sat;

endmodule

### sv/tps_checker.sv
// Port-level checker for the thin-plate spline evaluator, with its bind
`include "thin_plate_spline_evaluator_assert.svh"

module tps_checker
    import tps_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_cmd,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_map_u,
    input logic signed [31:0] o_map_v,
    input logic               o_saturated
);

    `TPS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_map_u) && $stable(o_map_v) && $stable(o_saturated), "stalled result changed")

    `TPS_ASSERT_NEXT(a_eval_busy, i_in_valid && !o_in_stall && (i_cmd == CMD_EVAL), o_in_stall, "input taken during evaluation")

    `TPS_ASSERT_NEXT(a_load_silent, i_in_valid && !o_in_stall && (i_cmd == CMD_LOAD) && !o_out_valid, !o_out_valid, "load item produced a result")

    `TPS_ASSERT_NOW(a_sat_clip, o_out_valid && o_saturated, (o_map_u == SAT_POS) || (o_map_u == SAT_NEG) || (o_map_v == SAT_POS) || (o_map_v == SAT_NEG), "saturated flag without a clipped value")

endmodule

bind thin_plate_spline_evaluator tps_checker u_tps_checker (.*);
